// File: hdl/ctss_pkg.sv
// shared types, constants and codes for the call target site scanner
// no dependencies; every module of the block imports this package
`default_nettype none

package ctss_pkg;

    // number of entries in the call target table
    localparam int TARGET_SLOTS = 16;

    // fill count holds 0..TARGET_SLOTS, slot index holds 0..TARGET_SLOTS-1
    localparam int SLOT_W = $clog2(TARGET_SLOTS + 1);
    localparam int IDX_W  = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;

    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int WIN_DEPTH = 4;
    localparam int LEN_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]        CALL_OPCODE = 8'he8;
    localparam logic [ADDR_W-1:0] CALL_LEN    = 32'd5;

    // input item selector
    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_SCAN    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_END   = 1'd1;

    // kind of token moving down the pipeline and the cell chain
    localparam logic [1:0] TOK_NONE    = 2'd0;
    localparam logic [1:0] TOK_SCAN    = 2'd1;
    localparam logic [1:0] TOK_APPEND  = 2'd2;
    localparam logic [1:0] TOK_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] site;   // candidate callsite
        logic [ADDR_W-1:0] data;   // displacement, call target or appended target
        logic [SLOT_W-1:0] fill;   // table fill snapshot, or slot for an append
        logic              hit;
        logic [IDX_W-1:0]  idx;
    } tok_t;

endpackage

`default_nettype wire

// File: hdl/call_target_site_scanner_unit.sv
// top level of the call target site scanner: config registers, pipeline, cell chain,
// found counter and output register; depends on ctss_pkg, ctss_front, ctss_target, ctss_cell
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   func, address, byte_value, read_fault,
//                                            target_address
//  out      source     out_valid / out_stall callsite, target_index, found_count
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while in_stall is low; a match passes through the front stage,
// the target stage, every table cell in turn and the output register
// the latency is set by the chain of table cells the call target walks through
// cfg_ready is always high; rst_n clears the table fill, window, counter and pipeline
// in_stall rises only while a finished result waits in the stalled output register
// and the next result has reached the end of the chain
`default_nettype none

module call_target_site_scanner_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output wire logic                            in_stall,
    input  wire logic [1:0]                      func,
    input  wire logic [31:0]                     address,
    input  wire logic [7:0]                      byte_value,
    input  wire logic                            read_fault,
    input  wire logic [31:0]                     target_address,

    output wire logic                            out_valid,
    input  wire logic                            out_stall,
    output wire logic [31:0]                     callsite,
    output wire logic [3:0]                      target_index,
    output wire logic [31:0]                     found_count,

    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [ctss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import ctss_pkg::*;

    logic [ADDR_W-1:0]  range_lo_reg;
    logic [ADDR_W-1:0]  range_hi_reg;

    logic               adv;
    logic               accept;
    tok_t               front_tok;
    tok_t               chain [TARGET_SLOTS+1];
    tok_t               last_tok;
    logic               last_hit;
    logic [ADDR_W-1:0]  last_site;
    logic [IDX_W+3:0]   idx_ext;

    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  callsite_reg;
    logic [3:0]         index_reg;
    logic [COUNT_W-1:0] found_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg <= '0;
            range_hi_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCAN_START: range_lo_reg <= cfg_data;
                REG_SCAN_END:   range_hi_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign last_tok  = chain[TARGET_SLOTS];
    assign last_hit  = (last_tok.kind == TOK_SCAN) && last_tok.hit;
    assign last_site = last_tok.site;

    // the whole chain moves unless a result would land on a stalled full output
    assign adv      = !(out_valid_reg && out_stall && last_hit);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    ctss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (func),
        .address        (address),
        .byte_value     (byte_value),
        .read_fault     (read_fault),
        .target_address (target_address),
        .range_lo       (range_lo_reg),
        .range_hi       (range_hi_reg),
        .adv            (adv),
        .tok_out        (front_tok)
    );

    ctss_target u_target (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .range_lo   (range_lo_reg),
        .range_hi   (range_hi_reg),
        .tok_in     (front_tok),
        .tok_out    (chain[0])
    );

    for (genvar i = 0; i < TARGET_SLOTS; i++)
    begin : g_cell
        ctss_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .slot    (SLOT_W'(i)),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign idx_ext   = {4'b0000, last_tok.idx};
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (last_tok.kind == TOK_RESTART)
            count_next = '0;
        else if (last_hit)
            count_next = count_inc;

        if (adv && last_hit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_hit)
        begin
            callsite_reg <= last_site;
            index_reg    <= idx_ext[3:0];
            found_reg    <= count_inc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign callsite     = callsite_reg;
    assign target_index = index_reg;
    assign found_count  = found_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last_hit) |=> (out_valid && (callsite == $past(last_site))))
        else $error("matched callsite not loaded into output register");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (found_count != '0))
        else $error("result carries zero found count");

    a_result_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !(adv && last_hit)) |=> !out_valid)
        else $error("taken result repeated");

endmodule

`default_nettype wire

// File: hdl/ctss_front.sv
// front end: byte window, address tracking, table fill count and candidate decode
// depends on ctss_pkg
`default_nettype none

module ctss_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [1:0]                func,
    input  wire logic [31:0]               address,
    input  wire logic [7:0]                byte_value,
    input  wire logic                      read_fault,
    input  wire logic [31:0]               target_address,
    input  wire logic [31:0]               range_lo,
    input  wire logic [31:0]               range_hi,
    input  wire logic                      adv,
    output ctss_pkg::tok_t                 tok_out
);
    import ctss_pkg::*;

    logic [WIN_DEPTH-1:0][7:0] bytes_reg, bytes_next;
    logic [WIN_DEPTH-1:0]      faults_reg, faults_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [ADDR_W-1:0]         prev_reg, prev_next;
    logic [SLOT_W-1:0]         fill_reg, fill_next;
    tok_t                      tok_reg, tok_next;

    logic                      gap;
    logic                      range_en;
    logic [WIN_DEPTH-1:0][7:0] eff_bytes;
    logic [WIN_DEPTH-1:0]      eff_faults;
    logic [LEN_W-1:0]          eff_len;

    always_comb
    begin
        gap = (len_reg != '0) &&
              ((prev_reg == '1) || (address != prev_reg + 32'd1));
        range_en = (range_lo < range_hi) && ((range_hi - range_lo) >= CALL_LEN);

        // a break in the address sequence empties the window
        eff_bytes  = gap ? '0 : bytes_reg;
        eff_faults = gap ? '1 : faults_reg;
        eff_len    = gap ? '0 : len_reg;

        bytes_next  = bytes_reg;
        faults_next = faults_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        fill_next   = fill_reg;
        tok_next    = '0;

        unique case (func)
            FUNC_APPEND:
            begin
                if (fill_reg < SLOT_W'(TARGET_SLOTS))
                begin
                    tok_next.kind = TOK_APPEND;
                    tok_next.data = target_address;
                    tok_next.fill = fill_reg;
                    fill_next     = fill_reg + 1'b1;
                end
            end
            FUNC_SCAN:
            begin
                if (!gap && (len_reg == LEN_W'(WIN_DEPTH)) && range_en &&
                    (faults_reg == '0) && !read_fault && (bytes_reg[0] == CALL_OPCODE))
                begin
                    tok_next.kind = TOK_SCAN;
                    tok_next.site = address - 32'd4;
                    tok_next.data = {byte_value, bytes_reg[3], bytes_reg[2], bytes_reg[1]};
                    tok_next.fill = fill_reg;
                end
                bytes_next  = {byte_value, eff_bytes[3], eff_bytes[2], eff_bytes[1]};
                faults_next = {read_fault, eff_faults[3], eff_faults[2], eff_faults[1]};
                len_next    = (eff_len == LEN_W'(WIN_DEPTH)) ? eff_len : eff_len + 1'b1;
                prev_next   = address;
            end
            FUNC_RESTART:
            begin
                tok_next.kind = TOK_RESTART;
                bytes_next    = '0;
                faults_next   = '1;
                len_next      = '0;
                prev_next     = '0;
                fill_next     = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg  <= '0;
            faults_reg <= '1;
            len_reg    <= '0;
            prev_reg   <= '0;
            fill_reg   <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                bytes_reg  <= bytes_next;
                faults_reg <= faults_next;
                len_reg    <= len_next;
                prev_reg   <= prev_next;
                fill_reg   <= fill_next;
            end
            if (adv)
                tok_reg <= accept ? tok_next : '0;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hdl/ctss_target.sv
// call target stage: forms site + 5 + displacement and checks callsite bounds
// depends on ctss_pkg
`default_nettype none

module ctss_target (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic [31:0]    range_lo,
    input  wire logic [31:0]    range_hi,
    input  wire ctss_pkg::tok_t tok_in,
    output ctss_pkg::tok_t      tok_out
);
    import ctss_pkg::*;

    tok_t        tok_reg, tok_next;
    logic [33:0] tsum;
    logic        site_ok;

    always_comb
    begin
        // 34-bit signed sum: top two bits flag a target below zero or past 2^32-1
        tsum = {2'b00, tok_in.site} + 34'(CALL_LEN) +
               {{2{tok_in.data[31]}}, tok_in.data};
        site_ok = (tok_in.site >= range_lo) && (tok_in.site <= range_hi - CALL_LEN);
        tok_next = tok_in;
        if (tok_in.kind == TOK_SCAN)
        begin
            tok_next.data = tsum[31:0];
            if (!site_ok || (tsum[33:32] != 2'b00))
                tok_next.kind = TOK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (adv)
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hdl/ctss_cell.sv
// one table cell: holds one call target and compares the passing transaction
// depends on ctss_pkg
`default_nettype none

module ctss_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic [ctss_pkg::SLOT_W-1:0]  slot,
    input  wire ctss_pkg::tok_t               tok_in,
    output ctss_pkg::tok_t                    tok_out
);
    import ctss_pkg::*;

    logic [ADDR_W-1:0] entry_reg;
    tok_t              tok_reg, tok_next;

    always_comb
    begin
        tok_next = tok_in;
        // only entries loaded before the scan was taken may match
        if ((tok_in.kind == TOK_SCAN) && !tok_in.hit && (slot < tok_in.fill) &&
            (entry_reg == tok_in.data))
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = slot[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (tok_in.kind == TOK_APPEND) && (tok_in.fill == slot))
            entry_reg <= tok_in.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (adv)
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
